// ===== sv/cetp_pkg.sv =====
// Shared types, constants and helpers for the color escape text parser.
`timescale 1ns / 1ps

package cetp_pkg;

    localparam logic [7:0] ESC_CODE     = 8'h15;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] RESTORE_CODE = 8'h72;
    localparam logic [7:0] DIGIT_0      = 8'h30;
    localparam logic [7:0] DIGIT_9      = 8'h39;
    localparam logic [7:0] LETTER_A     = 8'h61;
    localparam logic [7:0] LETTER_F     = 8'h66;
    localparam logic [7:0] LETTER_BIAS  = 8'h57;

    localparam logic [9:0] FULL_QUARTERS = 10'd1020;
    localparam logic [7:0] FULL_ALPHA    = 8'hFF;
    localparam logic [31:0] BASE_RESET   = 32'hFFFF_FFFF;

    localparam logic       REG_BASE_COLOR  = 1'b0;
    localparam logic       REG_SHADOW_MODE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [23:0] PALETTE [16] = '{
        24'h272727, 24'h2d44aa, 24'h094816, 24'h30c2ca,
        24'hdb161a, 24'h9730c3, 24'h583337, 24'hadaba8,
        24'h525557, 24'h8bd7ff, 24'h7bd53a, 24'hf68008,
        24'hf9aecd, 24'hd344b1, 24'hf9f618, 24'hffffff
    };

    typedef enum logic [1:0] {
        ACT_GLYPH   = 2'd0,
        ACT_SET     = 2'd1,
        ACT_NEWLINE = 2'd2,
        ACT_FINISH  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_GLYPH,
        KIND_NEWLINE,
        KIND_BASE,
        KIND_PALETTE,
        KIND_ESC,
        KIND_ESC_PAIR
    } kind_t;

    // One classified byte: which results it causes, in slot order.
    typedef struct packed {
        logic       start;
        kind_t      kind;
        logic [7:0] code;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic [31:0] base_color;
        logic        shadow;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Slots: bit 0 string-start color, bit 1 body, bit 2 second glyph, bit 3 finish.
    function automatic logic [3:0] cmd_mask(input cmd_t cmd);
        cmd_mask = {cmd.finish, cmd.kind == KIND_ESC_PAIR,
                    cmd.kind != KIND_NONE, cmd.start};
    endfunction

endpackage

// ===== sv/cetp_front.sv =====
// Front end: accepts text bytes, tracks escape and string-start state, classifies bytes.
`timescale 1ns / 1ps

module cetp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          code,
    input  logic                last,
    input  cetp_pkg::q_status_t q_status,
    output logic                push,
    output cetp_pkg::cmd_t      push_data
);

    logic in_escape_reg, in_escape_next;
    logic at_start_reg, at_start_next;
    logic accept;
    logic is_digit, is_letter;
    cetp_pkg::cmd_t cmd;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    always_comb
    begin
        is_digit  = (code >= cetp_pkg::DIGIT_0) && (code <= cetp_pkg::DIGIT_9);
        is_letter = (code >= cetp_pkg::LETTER_A) && (code <= cetp_pkg::LETTER_F);
        cmd.start  = at_start_reg;
        cmd.finish = last;
        cmd.code   = code;
        cmd.kind   = cetp_pkg::KIND_NONE;
        in_escape_next = in_escape_reg;
        at_start_next  = at_start_reg;
        if (in_escape_reg)
        begin
            if (code == cetp_pkg::NEWLINE_CODE)
                cmd.kind = cetp_pkg::KIND_NONE;
            else if (code == cetp_pkg::RESTORE_CODE)
                cmd.kind = cetp_pkg::KIND_BASE;
            else if (code == cetp_pkg::ESC_CODE)
                cmd.kind = cetp_pkg::KIND_ESC;
            else if (is_digit)
            begin
                cmd.kind = cetp_pkg::KIND_PALETTE;
                cmd.code = code - cetp_pkg::DIGIT_0;
            end
            else if (is_letter)
            begin
                cmd.kind = cetp_pkg::KIND_PALETTE;
                cmd.code = code - cetp_pkg::LETTER_BIAS;
            end
            else
                cmd.kind = cetp_pkg::KIND_ESC_PAIR;
        end
        else if (code == cetp_pkg::ESC_CODE)
            cmd.kind = last ? cetp_pkg::KIND_ESC : cetp_pkg::KIND_NONE;
        else if (code == cetp_pkg::NEWLINE_CODE)
            cmd.kind = cetp_pkg::KIND_NEWLINE;
        else
            cmd.kind = cetp_pkg::KIND_GLYPH;

        if (accept)
        begin
            in_escape_next = !in_escape_reg && (code == cetp_pkg::ESC_CODE) && !last;
            at_start_next  = last;
        end
    end

    // A byte that causes no result never enters the queue.
    assign push      = accept && (cetp_pkg::cmd_mask(cmd) != 4'd0);
    assign push_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_escape_reg <= 1'b0;
            at_start_reg  <= 1'b1;
        end
        else
        begin
            in_escape_reg <= in_escape_next;
            at_start_reg  <= at_start_next;
        end
    end

endmodule

// ===== sv/cetp_queue.sv =====
// Short command queue between the front end and the result expander.
`timescale 1ns / 1ps

module cetp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cetp_pkg::cmd_t      push_data,
    input  logic                pop,
    output cetp_pkg::cmd_t      pop_data,
    output cetp_pkg::q_status_t status
);

    cetp_pkg::cmd_t entry_reg [cetp_pkg::QUEUE_DEPTH];
    logic [cetp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cetp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cetp_pkg::QPTR_W:0]   cnt_reg, cnt_next;

    localparam logic [cetp_pkg::QPTR_W-1:0] LAST_PTR =
        cetp_pkg::QPTR_W'(cetp_pkg::QUEUE_DEPTH - 1);
    localparam logic [cetp_pkg::QPTR_W:0] FULL_CNT =
        (cetp_pkg::QPTR_W + 1)'(cetp_pkg::QUEUE_DEPTH);

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/cetp_back.sv =====
// Back end: expands each queued command into its results, one per cycle unless stalled.
`timescale 1ns / 1ps

module cetp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cetp_pkg::cfg_t      cfg,
    input  cetp_pkg::q_status_t q_status,
    input  cetp_pkg::cmd_t      q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          action,
    output logic [7:0]          glyph,
    output logic [9:0]          red,
    output logic [9:0]          green,
    output logic [9:0]          blue,
    output logic [7:0]          alpha,
    output logic                end_of_run
);

    cetp_pkg::cmd_t cur_reg, cur_next;
    logic [3:0] mask_reg, mask_next;
    logic [3:0] sel, rem, mask_after;
    logic       emit;

    logic       out_valid_reg, out_valid_next;
    cetp_pkg::action_t act_reg, act_next;
    logic [7:0] glyph_reg, glyph_next;
    logic [9:0] red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [7:0] alpha_reg, alpha_next;
    logic       eor_reg, eor_next;

    logic [7:0]  shown_alpha;
    logic [9:0]  base_r, base_g, base_b, pal_r, pal_g, pal_b;
    logic [23:0] pal;

    always_comb
    begin
        shown_alpha = (cfg.base_color[31:24] == 8'd0) ? cetp_pkg::FULL_ALPHA
                                                      : cfg.base_color[31:24];
        if (cfg.shadow)
        begin
            base_r = {2'b00, cfg.base_color[23:18], 2'b00};
            base_g = {2'b00, cfg.base_color[15:10], 2'b00};
            base_b = {2'b00, cfg.base_color[7:2], 2'b00};
        end
        else
        begin
            base_r = {cfg.base_color[23:16], 2'b00};
            base_g = {cfg.base_color[15:8], 2'b00};
            base_b = {cfg.base_color[7:0], 2'b00};
        end
        pal = cetp_pkg::PALETTE[cur_reg.code[3:0]];
        if (cfg.shadow)
        begin
            pal_r = {2'b00, pal[23:16]};
            pal_g = {2'b00, pal[15:8]};
            pal_b = {2'b00, pal[7:0]};
        end
        else
        begin
            pal_r = {pal[23:16], 2'b00};
            pal_g = {pal[15:8], 2'b00};
            pal_b = {pal[7:0], 2'b00};
        end
    end

    always_comb
    begin
        // Lowest pending slot goes out first.
        sel = mask_reg & (~mask_reg + 4'd1);
        rem = mask_reg & ~sel;
        emit = (mask_reg != 4'd0) && (!out_valid_reg || !out_stall);
        mask_after = emit ? rem : mask_reg;
        pop = (mask_after == 4'd0) && !q_status.empty;
        mask_next = pop ? cetp_pkg::cmd_mask(q_data) : mask_after;
        cur_next  = pop ? q_data : cur_reg;
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_comb
    begin
        act_next   = cetp_pkg::ACT_GLYPH;
        glyph_next = 8'd0;
        red_next   = 10'd0;
        green_next = 10'd0;
        blue_next  = 10'd0;
        alpha_next = 8'd0;
        eor_next   = (rem == 4'd0);
        case (sel)
            4'b0001:
            begin
                act_next   = cetp_pkg::ACT_SET;
                red_next   = base_r;
                green_next = base_g;
                blue_next  = base_b;
                alpha_next = shown_alpha;
            end
            4'b0010:
            begin
                case (cur_reg.kind)
                    cetp_pkg::KIND_GLYPH:
                        glyph_next = cur_reg.code;
                    cetp_pkg::KIND_NEWLINE:
                        act_next = cetp_pkg::ACT_NEWLINE;
                    cetp_pkg::KIND_BASE:
                    begin
                        act_next   = cetp_pkg::ACT_SET;
                        red_next   = base_r;
                        green_next = base_g;
                        blue_next  = base_b;
                        alpha_next = shown_alpha;
                    end
                    cetp_pkg::KIND_PALETTE:
                    begin
                        act_next   = cetp_pkg::ACT_SET;
                        red_next   = pal_r;
                        green_next = pal_g;
                        blue_next  = pal_b;
                        alpha_next = shown_alpha;
                    end
                    default:
                        glyph_next = cetp_pkg::ESC_CODE;
                endcase
            end
            4'b0100:
                glyph_next = cur_reg.code;
            4'b1000:
            begin
                act_next   = cetp_pkg::ACT_FINISH;
                red_next   = cetp_pkg::FULL_QUARTERS;
                green_next = cetp_pkg::FULL_QUARTERS;
                blue_next  = cetp_pkg::FULL_QUARTERS;
                alpha_next = cetp_pkg::FULL_ALPHA;
            end
            default:
                eor_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            act_reg   <= act_next;
            glyph_reg <= glyph_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            eor_reg   <= eor_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = act_reg;
    assign glyph      = glyph_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign alpha      = alpha_reg;
    assign end_of_run = eor_reg;

endmodule

// ===== sv/color_escape_text_parser_top.sv =====
// Top level of the color escape text parser: registers, front end, queue and back end.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  code, last
// output    out        out_valid / out_stall action, glyph, red, green, blue, alpha, end_of_run
// config    in         cfg_write            cfg_index, cfg_data
//
// A byte causes up to three results; the back end sends one result per cycle
// while out_stall is low, and bytes with no result never enter the queue.
// The front end takes a new byte every cycle while the two-entry command queue has room.
// Reset clears the escape state, sets string start, and loads base color white, shadow off.
// A stall on the output holds the output register; the queue absorbs bytes meanwhile.

module color_escape_text_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  code,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [7:0]  glyph,
    output logic [9:0]  red,
    output logic [9:0]  green,
    output logic [9:0]  blue,
    output logic [7:0]  alpha,
    output logic        end_of_run,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    cetp_pkg::cfg_t      cfg_reg, cfg_next;
    cetp_pkg::q_status_t q_status;
    cetp_pkg::cmd_t      push_data, pop_data;
    logic                push, pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                cetp_pkg::REG_BASE_COLOR:  cfg_next.base_color = cfg_data;
                cetp_pkg::REG_SHADOW_MODE: cfg_next.shadow     = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_color <= cetp_pkg::BASE_RESET;
            cfg_reg.shadow     <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    cetp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .code      (code),
        .last      (last),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    cetp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    cetp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .q_data     (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .glyph      (glyph),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .end_of_run (end_of_run)
    );

    // The finish result always closes the run of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == 2'(cetp_pkg::ACT_FINISH)) |-> end_of_run)
        else $error("finish result without end of run");

    // Glyph and new-line results carry no color.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((action == 2'(cetp_pkg::ACT_GLYPH)) ||
                      (action == 2'(cetp_pkg::ACT_NEWLINE)))
        |-> (red == 10'd0) && (green == 10'd0) && (blue == 10'd0) && (alpha == 8'd0))
        else $error("color on a non-color result");

    // The front end never writes into a full queue, and the back end never reads an empty one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full) && !(pop && q_status.empty))
        else $error("queue overflow or underflow");

endmodule
